### rtl/core/mmsr_pkg.sv
package mmsr_pkg;

   // fixed field widths of the stream ports
   localparam int REQ_DATA_WIDTH = 32;
   localparam int RSP_DATA_WIDTH = 64;
   localparam int MODE_WIDTH     = 3;

   typedef logic [MODE_WIDTH-1:0] mode_type;

   localparam mode_type MODE_SUM      = 3'd0;
   localparam mode_type MODE_SUM_ABS  = 3'd1;
   localparam mode_type MODE_SUM_SQR  = 3'd2;
   localparam mode_type MODE_MAX      = 3'd3;
   localparam mode_type MODE_MIN      = 3'd4;
   localparam mode_type MODE_MAX_ABS  = 3'd5;
   localparam mode_type MODE_MIN_ABS  = 3'd6;
   localparam mode_type MODE_RESERVED = 3'd7;

endpackage

### rtl/core/multi_mode_stream_reducer_unit.sv
// Streaming reducer: one signed element per req transaction (low ELEMENT_WIDTH bits of
// req_tdata), req_tlast closing a region. csr_data selects sum, sum of absolute values,
// sum of squares, max, min, max abs or min abs; code 7 leaves the accumulator as it is.
// On the closing element one rsp transaction carries the region's result, sign-extended
// from ACCUM_WIDTH to 64 bits, and the accumulator restarts. Sums wrap at ACCUM_WIDTH.
// One element is taken per cycle unless a stall holds it; each passes an input register
// and an operand register (sign extension, absolute value, square) into the accumulator;
// a closing element's result is registered instead. Only a result left waiting on
// rsp_tready holds up the next closing element. Write csr_data only while idle.
module multi_mode_stream_reducer_unit #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int ACCUM_WIDTH   = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mmsr_pkg::REQ_DATA_WIDTH-1:0] req_tdata,   // [31:0] element_value
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mmsr_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,   // [63:0] reduced_value
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mmsr_pkg::MODE_WIDTH-1:0]     csr_data     // [2:0] reduce_mode
);

   mmsr_pkg::mode_type     mode_ff;
   logic                   op_valid, op_ready, op_last;
   logic [ACCUM_WIDTH-1:0] op_x, op_abs, op_sqr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mmsr_pkg::MODE_SUM;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   mmsr_prep #(
      .ELEMENT_WIDTH (ELEMENT_WIDTH),
      .ACCUM_WIDTH   (ACCUM_WIDTH)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_value (req_tdata),
      .in_last  (req_tlast),
      .op_valid (op_valid),
      .op_ready (op_ready),
      .op_x     (op_x),
      .op_abs   (op_abs),
      .op_sqr   (op_sqr),
      .op_last  (op_last)
   );

   mmsr_accum #(
      .ACCUM_WIDTH (ACCUM_WIDTH)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op_x      (op_x),
      .op_abs    (op_abs),
      .op_sqr    (op_sqr),
      .op_last   (op_last),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (rsp_tdata)
   );

endmodule

### rtl/core/mmsr_prep.sv
module mmsr_prep #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int ACCUM_WIDTH   = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [mmsr_pkg::REQ_DATA_WIDTH-1:0] in_value,
   input  logic                                in_last,
   output logic                                op_valid,
   input  logic                                op_ready,
   output logic [ACCUM_WIDTH-1:0]              op_x,
   output logic [ACCUM_WIDTH-1:0]              op_abs,
   output logic [ACCUM_WIDTH-1:0]              op_sqr,
   output logic                                op_last
);

   localparam int WIDE     = (ACCUM_WIDTH > ELEMENT_WIDTH) ? ACCUM_WIDTH : ELEMENT_WIDTH;
   localparam int PROD_W   = 2 * ELEMENT_WIDTH;
   localparam int SQR_WIDE = (ACCUM_WIDTH > PROD_W) ? ACCUM_WIDTH : PROD_W;

   logic                     a_valid_ff, a_valid_in;
   logic [ELEMENT_WIDTH-1:0] a_value_ff;
   logic                     a_last_ff;
   logic                     b_valid_ff, b_valid_in;
   logic [ACCUM_WIDTH-1:0]   b_x_ff, b_abs_ff, b_sqr_ff;
   logic                     b_last_ff;

   logic                     b_take;
   logic                     a_move;
   logic [WIDE-1:0]          x_wide;
   logic [ACCUM_WIDTH-1:0]   x_acc;
   logic [ACCUM_WIDTH-1:0]   abs_acc;
   logic signed [PROD_W-1:0] prod;
   logic [SQR_WIDE-1:0]      prod_wide;

   assign b_take   = b_valid_ff && op_ready;
   assign a_move   = a_valid_ff && (!b_valid_ff || b_take);
   assign in_ready = !a_valid_ff || a_move;

   assign a_valid_in = (in_valid && in_ready) || (a_valid_ff && !a_move);
   assign b_valid_in = a_move || (b_valid_ff && !b_take);

   // operands formed at accumulator width, wrapping like the accumulator
   assign x_wide  = WIDE'($signed(a_value_ff));
   assign x_acc   = x_wide[ACCUM_WIDTH-1:0];
   assign abs_acc = a_value_ff[ELEMENT_WIDTH-1] ? (~x_acc + ACCUM_WIDTH'(1)) : x_acc;
   // the square is never negative, so zero extension is exact
   assign prod      = $signed(a_value_ff) * $signed(a_value_ff);
   assign prod_wide = SQR_WIDE'($unsigned(prod));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         a_value_ff <= in_value[ELEMENT_WIDTH-1:0];
         a_last_ff  <= in_last;
      end
      if (a_move) begin
         b_x_ff    <= x_acc;
         b_abs_ff  <= abs_acc;
         b_sqr_ff  <= prod_wide[ACCUM_WIDTH-1:0];
         b_last_ff <= a_last_ff;
      end
   end

   assign op_valid = b_valid_ff;
   assign op_x     = b_x_ff;
   assign op_abs   = b_abs_ff;
   assign op_sqr   = b_sqr_ff;
   assign op_last  = b_last_ff;

endmodule

### rtl/core/mmsr_accum.sv
module mmsr_accum #(
   parameter int ACCUM_WIDTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mmsr_pkg::mode_type                  mode,
   input  logic                                op_valid,
   output logic                                op_ready,
   input  logic [ACCUM_WIDTH-1:0]              op_x,
   input  logic [ACCUM_WIDTH-1:0]              op_abs,
   input  logic [ACCUM_WIDTH-1:0]              op_sqr,
   input  logic                                op_last,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [mmsr_pkg::RSP_DATA_WIDTH-1:0] out_value
);

   logic                   acc_first_ff, acc_first_in;
   logic [ACCUM_WIDTH-1:0] acc_ff, acc_in;
   logic                   out_valid_ff, out_valid_in;
   logic [mmsr_pkg::RSP_DATA_WIDTH-1:0] out_value_ff;

   logic                   fire;
   logic                   emit;
   logic [ACCUM_WIDTH-1:0] cand;
   logic [ACCUM_WIDTH-1:0] acc_next;
   logic                   cand_less;

   // a last element waits only while the result register is still occupied
   assign op_ready = !op_last || !out_valid_ff || out_ready;
   assign fire     = op_valid && op_ready;
   assign emit     = fire && op_last;

   assign cand      = (mode == mmsr_pkg::MODE_MAX || mode == mmsr_pkg::MODE_MIN) ? op_x : op_abs;
   assign cand_less = $signed(cand) < $signed(acc_ff);

   always_comb begin
      acc_next = acc_ff;
      case (mode) inside
         mmsr_pkg::MODE_SUM:     acc_next = acc_ff + op_x;
         mmsr_pkg::MODE_SUM_ABS: acc_next = acc_ff + op_abs;
         mmsr_pkg::MODE_SUM_SQR: acc_next = acc_ff + op_sqr;
         mmsr_pkg::MODE_MAX, mmsr_pkg::MODE_MAX_ABS: begin
            if (acc_first_ff || (!cand_less && cand != acc_ff)) acc_next = cand;
         end
         mmsr_pkg::MODE_MIN, mmsr_pkg::MODE_MIN_ABS: begin
            if (acc_first_ff || cand_less) acc_next = cand;
         end
         default: acc_next = acc_ff;
      endcase
   end

   always_comb begin
      acc_in       = acc_ff;
      acc_first_in = acc_first_ff;
      if (fire) begin
         acc_in       = op_last ? '0 : acc_next;
         acc_first_in = op_last;
      end
   end

   assign out_valid_in = emit || (out_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         acc_first_ff <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         acc_first_ff <= acc_first_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_value_ff <= mmsr_pkg::RSP_DATA_WIDTH'($signed(acc_next));
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;

endmodule
